FILE: hdl/exception_handler_record_checker_assert.svh
// Assertion macros for the exception handler record checker
`ifndef EXCEPTION_HANDLER_RECORD_CHECKER_ASSERT_SVH
`define EXCEPTION_HANDLER_RECORD_CHECKER_ASSERT_SVH

`ifndef SYNTHESIS

// check a property on every clock edge outside reset
`define EHRC_ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ehrc: assertion failed");

// check a property on every clock edge, reset included
`define EHRC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("ehrc: assertion failed");

`else

`define EHRC_ASSERT_RST(lbl, clk, rst, prop)
`define EHRC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: hdl/ehrc_pkg.sv
// Shared types and constants of the exception handler record checker
package ehrc_pkg;

   localparam int unsigned TABLE_DEPTH_DEF = 256;

   localparam logic [31:0] ALIGN_MASK = 32'((1 << 2) - 1);

   // input word kinds
   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_VERIFY = 1'b1;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W   = 3;
   localparam logic [2:0] CSR_STACK_LOW  = 3'd0;
   localparam logic [2:0] CSR_STACK_HIGH = 3'd1;
   localparam logic [2:0] CSR_IMAGE_BASE = 3'd2;
   localparam logic [2:0] CSR_HND_COUNT  = 3'd3;
   localparam logic [2:0] CSR_SAFE_ON    = 3'd4;
   localparam logic [2:0] CSR_TABLE_PRES = 3'd5;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_BAD_RECORD  = 2'd1,
      STATUS_BAD_STACK   = 2'd2,
      STATUS_NOT_ALLOWED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_PROBE,
      S_COMPARE,
      S_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       write_entry;
      logic       capture;
      logic       start;
      logic       probe;
      logic       narrow;
      logic       set_code;
      status_type code;
      logic       emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       pre_done;
      status_type pre_code;
      logic       range_empty;
      logic       match;
      logic       out_full;
   } sts_type;

endpackage

FILE: hdl/ehrc_ctrl.sv
// Controller state machine: sequences capture, prechecks, search and result
`include "exception_handler_record_checker_assert.svh"

module ehrc_ctrl
   import ehrc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_kind,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.code  = STATUS_OK;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_kind == KIND_LOAD) begin
                  cmd.write_entry = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (sts.pre_done) begin
               cmd.set_code = 1'b1;
               cmd.code     = sts.pre_code;
               state_in     = S_FINISH;
            end else begin
               cmd.start = 1'b1;
               state_in  = S_PROBE;
            end
         end
         S_PROBE: begin
            if (sts.range_empty) begin
               cmd.set_code = 1'b1;
               cmd.code     = STATUS_NOT_ALLOWED;
               state_in     = S_FINISH;
            end else begin
               cmd.probe = 1'b1;
               state_in  = S_COMPARE;
            end
         end
         S_COMPARE: begin
            if (sts.match) begin
               cmd.set_code = 1'b1;
               cmd.code     = STATUS_OK;
               state_in     = S_FINISH;
            end else begin
               cmd.narrow = 1'b1;
               state_in   = S_PROBE;
            end
         end
         S_FINISH: begin
            if (!sts.out_full) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `EHRC_ASSERT_RST(a_verify_goes_check, clock, reset,
      (state_ff == S_IDLE && req_valid && req_kind == KIND_VERIFY) |=> (state_ff == S_CHECK))
   `EHRC_ASSERT_RST(a_compare_after_probe, clock, reset,
      (state_ff == S_COMPARE) |-> ($past(state_ff) == S_PROBE))
   `EHRC_ASSERT_RST(a_probe_reads, clock, reset,
      (state_ff == S_PROBE && !sts.range_empty) |=> (state_ff == S_COMPARE))
   `EHRC_ASSERT_RST(a_finish_drains, clock, reset,
      (state_ff == S_FINISH && !sts.out_full) |=> (state_ff == S_IDLE))

endmodule

FILE: hdl/ehrc_dp.sv
// Datapath: registers, allowed handler table, checks, search bounds, output word
module ehrc_dp
   import ehrc_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata,
   input  logic [7:0]             req_entry_index,
   input  logic [31:0]            req_entry_offset,
   input  logic [31:0]            req_record_addr,
   input  logic [31:0]            req_next_addr,
   input  logic [31:0]            req_handler_addr,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   input  cmd_type                cmd,
   output sts_type                sts
);

   localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

   logic [31:0] stack_low_ff;
   logic [31:0] stack_high_ff;
   logic [31:0] image_base_ff;
   logic [8:0]  handler_count_ff;
   logic        safe_on_ff;
   logic        table_pres_ff;

   logic [31:0] mem [TABLE_DEPTH];

   logic [31:0] rec_ff;
   logic [31:0] next_ff;
   logic [31:0] hnd_ff;
   logic [31:0] offset_ff;
   logic [31:0] rdata_ff;
   logic [CNT_W-1:0] lo_ff;
   logic [CNT_W-1:0] hi_ff;
   logic [CNT_W-1:0] mid_ff;
   status_type  code_ff;
   logic        rsp_valid_ff;
   status_type  rsp_status_ff;

   logic [31:0]      slot_wide;
   logic             slot_ok;
   logic [31:0]      cnt_wide;
   logic [31:0]      cnt_clamp;
   logic [CNT_W:0]   mid_sum;
   logic [CNT_W-1:0] mid;
   logic             bad_record;
   logic             bad_stack;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stack_low_ff     <= '0;
         stack_high_ff    <= '0;
         image_base_ff    <= '0;
         handler_count_ff <= '0;
         safe_on_ff       <= 1'b0;
         table_pres_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STACK_LOW:  stack_low_ff     <= csr_wdata;
            CSR_STACK_HIGH: stack_high_ff    <= csr_wdata;
            CSR_IMAGE_BASE: image_base_ff    <= csr_wdata;
            CSR_HND_COUNT:  handler_count_ff <= csr_wdata[8:0];
            CSR_SAFE_ON:    safe_on_ff       <= csr_wdata[0];
            CSR_TABLE_PRES: table_pres_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // table slot and search bound arithmetic
   assign slot_wide = {24'd0, req_entry_index};
   assign slot_ok   = slot_wide < 32'(TABLE_DEPTH);
   assign cnt_wide  = {23'd0, handler_count_ff};
   assign cnt_clamp = (cnt_wide > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : cnt_wide;
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = mid_sum[CNT_W:1];

   // write and read the allowed handler table
   always_ff @(posedge clock) begin
      if (cmd.write_entry && slot_ok) begin
         mem[slot_wide[IDX_W-1:0]] <= req_entry_offset;
      end
      if (cmd.probe) begin
         rdata_ff <= mem[mid[IDX_W-1:0]];
      end
   end

   // capture the record and advance the search window
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rec_ff  <= req_record_addr;
         next_ff <= req_next_addr;
         hnd_ff  <= req_handler_addr;
      end
      if (cmd.start) begin
         offset_ff <= hnd_ff - image_base_ff;
         lo_ff     <= '0;
         hi_ff     <= cnt_clamp[CNT_W-1:0];
      end
      if (cmd.probe) begin
         mid_ff <= mid;
      end
      if (cmd.narrow) begin
         if (offset_ff > rdata_ff) begin
            lo_ff <= CNT_W'(mid_ff + 1'b1);
         end else begin
            hi_ff <= mid_ff;
         end
      end
      if (cmd.set_code) begin
         code_ff <= cmd.code;
      end
   end

   // hold the result word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= code_ff;
      end
   end

   // record shape and stack bound checks
   assign bad_record = ((rec_ff & ALIGN_MASK) != 32'd0) || !(rec_ff < next_ff)
                       || (hnd_ff == 32'd0);
   assign bad_stack  = (stack_low_ff != 32'd0) && (stack_high_ff != 32'd0)
                       && ((rec_ff < stack_low_ff) || (rec_ff > stack_high_ff));

   // status toward the controller
   always_comb begin
      sts.range_empty = !(lo_ff < hi_ff);
      sts.match       = (offset_ff == rdata_ff);
      sts.out_full    = rsp_valid_ff && rsp_stall;
      sts.pre_done    = 1'b1;
      sts.pre_code    = STATUS_OK;
      if (bad_record) begin
         sts.pre_code = STATUS_BAD_RECORD;
      end else if (bad_stack) begin
         sts.pre_code = STATUS_BAD_STACK;
      end else if (!safe_on_ff) begin
         sts.pre_code = STATUS_OK;
      end else if (!table_pres_ff) begin
         sts.pre_code = STATUS_NOT_ALLOWED;
      end else begin
         sts.pre_done = 1'b0;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule

FILE: hdl/exception_handler_record_checker.sv
// A verify word passes from the check state to the finish state without a table
// search, or through a table search first; each search step is one table read plus
// one compare in the controller loop. Load words are taken one per cycle while no
// verify is in work and give no result; one verify is in work at a time.
// Synchronous active-high reset clears control state, configuration registers and the
// output valid; table contents are undefined until loaded.
module exception_handler_record_checker
   import ehrc_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_kind,
   input  logic [7:0]             req_entry_index,
   input  logic [31:0]            req_entry_offset,
   input  logic [31:0]            req_record_addr,
   input  logic [31:0]            req_next_addr,
   input  logic [31:0]            req_handler_addr,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_status
);

   cmd_type cmd;
   sts_type sts;

   ehrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ehrc_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_entry_index  (req_entry_index),
      .req_entry_offset (req_entry_offset),
      .req_record_addr  (req_record_addr),
      .req_next_addr    (req_next_addr),
      .req_handler_addr (req_handler_addr),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the exception handler record checker
module tb_top;
   import ehrc_pkg::*;

   localparam int unsigned DRILL_LEN       = 35;
   localparam int unsigned PHASES          = 10;
   localparam int unsigned WORDS_PER_PHASE = 127;
   localparam int unsigned SETTLE_CYCLES   = 30;
   localparam int unsigned HOLD_CYCLES     = 300;
   localparam int unsigned QUIET_LIMIT     = 4000;

   // indexes past the last register, which the block must ignore
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 3'd7;

   typedef enum int {PACE_FULL, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_type;
   typedef enum logic {STEP_REG, STEP_WORD} step_kind_type;

   // register steps carry the register index in slot and its value in offset
   typedef struct packed {
      step_kind_type what;
      logic          kind;
      logic [7:0]    slot;
      logic [31:0]   offset;
      logic [31:0]   rec;
      logic [31:0]   nxt;
      logic [31:0]   hnd;
      logic          typed;
      status_type    status;
   } drill_step_type;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   csr_we           = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [31:0]            csr_wdata        = '0;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic                   req_kind         = 1'b0;
   logic [7:0]             req_entry_index  = '0;
   logic [31:0]            req_entry_offset = '0;
   logic [31:0]            req_record_addr  = '0;
   logic [31:0]            req_next_addr    = '0;
   logic [31:0]            req_handler_addr = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic [1:0]             rsp_status;

   // shadow copy of the block's registers and handler table
   logic [31:0] cfg_stack_low      = '0;
   logic [31:0] cfg_stack_high     = '0;
   logic [31:0] cfg_image_base     = '0;
   logic [8:0]  cfg_count          = '0;
   logic        cfg_safe_on        = 1'b0;
   logic        cfg_table_present  = 1'b0;
   logic [31:0] handler_table [TABLE_DEPTH_DEF];

   status_type  status_q [$];
   pace_type    pace         = PACE_FULL;
   bit          hold_request = 1'b0;
   int unsigned hold_left    = 0;
   int unsigned faults       = 0;
   int unsigned loads_seen   = 0;
   int unsigned checks_seen  = 0;
   int unsigned settings_seen = 1;
   int unsigned tally [4]    = '{0, 0, 0, 0};

   drill_step_type drill [DRILL_LEN] = '{
      // after reset, record shape rules
      '{STEP_WORD, KIND_VERIFY, 8'h00, 32'h0000_0000, 32'h0000_1000, 32'h0000_2000,
        32'h0000_0001, 1'b1, STATUS_OK},
      '{STEP_WORD, KIND_VERIFY, 8'hFF, 32'hFFFF_FFFF, 32'h0000_1001, 32'h0000_2000,
        32'h0000_0001, 1'b1, STATUS_BAD_RECORD},
      '{STEP_WORD, KIND_VERIFY, 8'h00, 32'h0000_0000, 32'h0000_1003, 32'h0000_2000,
        32'h0000_0001, 1'b1, STATUS_BAD_RECORD},
      '{STEP_WORD, KIND_VERIFY, 8'h00, 32'h0000_0000, 32'h0000_2000, 32'h0000_2000,
        32'h0000_0001, 1'b1, STATUS_BAD_RECORD},
      '{STEP_WORD, KIND_VERIFY, 8'h00, 32'h0000_0000, 32'h0000_1000, 32'h0000_2000,
        32'h0000_0000, 1'b1, STATUS_BAD_RECORD},
      '{STEP_WORD, KIND_VERIFY, 8'h00, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001,
        32'hFFFF_FFFF, 1'b1, STATUS_OK},
      '{STEP_WORD, KIND_VERIFY, 8'h00, 32'h0000_0000, 32'hFFFF_FFFC, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 1'b1, STATUS_OK},
      '{STEP_WORD, KIND_VERIFY, 8'h00, 32'h0000_0000, 32'hFFFF_FFFC, 32'h0000_0000,
        32'h0000_0001, 1'b1, STATUS_BAD_RECORD},
      // stack bounds, both edges inclusive
      '{STEP_REG, KIND_LOAD, CSR_STACK_LOW, 32'h0000_1000, 32'h0, 32'h0, 32'h0,
        1'b0, STATUS_OK},
      '{STEP_REG, KIND_LOAD, CSR_STACK_HIGH, 32'h0000_1FFC, 32'h0, 32'h0, 32'h0,
        1'b0, STATUS_OK},
      '{STEP_WORD, KIND_VERIFY, 8'h00, 32'h0000_0000, 32'h0000_1000, 32'h0000_2000,
        32'h0000_0001, 1'b1, STATUS_OK},
      '{STEP_WORD, KIND_VERIFY, 8'h00, 32'h0000_0000, 32'h0000_1FFC, 32'h0000_2000,
        32'h0000_0001, 1'b1, STATUS_OK},
      '{STEP_WORD, KIND_VERIFY, 8'h00, 32'h0000_0000, 32'h0000_0FFC, 32'h0000_2000,
        32'h0000_0001, 1'b1, STATUS_BAD_STACK},
      '{STEP_WORD, KIND_VERIFY, 8'h00, 32'h0000_0000, 32'h0000_2000, 32'h0000_3000,
        32'h0000_0001, 1'b1, STATUS_BAD_STACK},
      '{STEP_WORD, KIND_VERIFY, 8'h00, 32'h0000_0000, 32'h0000_2001, 32'h0000_3000,
        32'h0000_0001, 1'b1, STATUS_BAD_RECORD},
      // one bound zero turns the stack check off
      '{STEP_REG, KIND_LOAD, CSR_STACK_LOW, 32'h0000_0000, 32'h0, 32'h0, 32'h0,
        1'b0, STATUS_OK},
      '{STEP_WORD, KIND_VERIFY, 8'h00, 32'h0000_0000, 32'h0000_8000, 32'h0000_9000,
        32'h0000_0001, 1'b1, STATUS_OK},
      '{STEP_REG, KIND_LOAD, CSR_SPARE_A, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
        1'b0, STATUS_OK},
      '{STEP_REG, KIND_LOAD, CSR_SPARE_B, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
        1'b0, STATUS_OK},
      '{STEP_WORD, KIND_VERIFY, 8'h00, 32'h0000_0000, 32'h0000_8000, 32'h0000_9000,
        32'h0000_0001, 1'b1, STATUS_OK},
      // small sorted table with both extreme offsets
      '{STEP_WORD, KIND_LOAD, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 1'b0, STATUS_OK},
      '{STEP_WORD, KIND_LOAD, 8'h01, 32'h0000_0100, 32'h0, 32'h0, 32'h0,
        1'b0, STATUS_OK},
      '{STEP_WORD, KIND_LOAD, 8'h02, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0,
        1'b0, STATUS_OK},
      '{STEP_WORD, KIND_LOAD, 8'h03, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
        1'b0, STATUS_OK},
      '{STEP_REG, KIND_LOAD, CSR_IMAGE_BASE, 32'h0000_0010, 32'h0, 32'h0, 32'h0,
        1'b0, STATUS_OK},
      '{STEP_REG, KIND_LOAD, CSR_HND_COUNT, 32'h0000_0004, 32'h0, 32'h0, 32'h0,
        1'b0, STATUS_OK},
      '{STEP_REG, KIND_LOAD, CSR_SAFE_ON, 32'h0000_0001, 32'h0, 32'h0, 32'h0,
        1'b0, STATUS_OK},
      // check on but no table present
      '{STEP_WORD, KIND_VERIFY, 8'h00, 32'h0000_0000, 32'h0000_1000, 32'h0000_2000,
        32'h0000_0110, 1'b1, STATUS_NOT_ALLOWED},
      '{STEP_REG, KIND_LOAD, CSR_TABLE_PRES, 32'h0000_0001, 32'h0, 32'h0, 32'h0,
        1'b0, STATUS_OK},
      // hits, a wrapped offset and a miss
      '{STEP_WORD, KIND_VERIFY, 8'h00, 32'h0000_0000, 32'h0000_1000, 32'h0000_2000,
        32'h0000_0110, 1'b0, STATUS_OK},
      '{STEP_WORD, KIND_VERIFY, 8'h00, 32'h0000_0000, 32'h0000_1000, 32'h0000_2000,
        32'h0000_000F, 1'b0, STATUS_OK},
      '{STEP_WORD, KIND_VERIFY, 8'h00, 32'h0000_0000, 32'h0000_1000, 32'h0000_2000,
        32'h0000_0010, 1'b0, STATUS_OK},
      '{STEP_WORD, KIND_VERIFY, 8'h00, 32'h0000_0000, 32'h0000_1000, 32'h0000_2000,
        32'h0000_0011, 1'b0, STATUS_OK},
      '{STEP_REG, KIND_LOAD, CSR_HND_COUNT, 32'h0000_0000, 32'h0, 32'h0, 32'h0,
        1'b0, STATUS_OK},
      // empty table finds nothing
      '{STEP_WORD, KIND_VERIFY, 8'h00, 32'h0000_0000, 32'h0000_1000, 32'h0000_2000,
        32'h0000_0110, 1'b1, STATUS_NOT_ALLOWED}
   };

   exception_handler_record_checker i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_entry_index  (req_entry_index),
      .req_entry_offset (req_entry_offset),
      .req_record_addr  (req_record_addr),
      .req_next_addr    (req_next_addr),
      .req_handler_addr (req_handler_addr),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // status of one record under the current registers and table
   function automatic status_type record_status(input logic [31:0] rec,
                                                input logic [31:0] nxt,
                                                input logic [31:0] hnd);
      logic [31:0] offset;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      bit          found;
      if ((rec & ALIGN_MASK) != 0 || !(rec < nxt) || hnd == 0)
         return STATUS_BAD_RECORD;
      if (cfg_stack_low != 0 && cfg_stack_high != 0 &&
          (rec < cfg_stack_low || rec > cfg_stack_high))
         return STATUS_BAD_STACK;
      if (cfg_safe_on) begin
         offset = hnd - cfg_image_base;
         lo = 0;
         hi = (cfg_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : cfg_count;
         found = 1'b0;
         while (lo < hi && !found) begin
            mid = (lo + hi) >> 1;
            if (offset > handler_table[mid])
               lo = mid + 1;
            else if (offset < handler_table[mid])
               hi = mid;
            else
               found = 1'b1;
         end
         if (!cfg_table_present || !found)
            return STATUS_NOT_ALLOWED;
      end
      return STATUS_OK;
   endfunction

   // offer one word, hold it until taken, then update the shadow state
   task automatic send_word(input logic kind, input logic [7:0] slot,
                            input logic [31:0] offset, input logic [31:0] rec,
                            input logic [31:0] nxt, input logic [31:0] hnd,
                            input logic typed, input status_type status);
      status_type want;
      int         pct;
      pct = (pace == PACE_SENDER) ? 74 : (pace == PACE_BOTH) ? 32 : 0;
      while ($urandom_range(99) < pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_entry_index  <= slot;
      req_entry_offset <= offset;
      req_record_addr  <= rec;
      req_next_addr    <= nxt;
      req_handler_addr <= hnd;
      do @(posedge clock); while (req_stall);
      if (kind == KIND_LOAD) begin
         handler_table[slot] = offset;
         loads_seen++;
      end else begin
         want = typed ? status : record_status(rec, nxt, hnd);
         status_q.push_back(want);
         tally[int'(want)]++;
         checks_seen++;
      end
   endtask

   // drop valid, drain pending statuses, then let in-flight loads finish
   task automatic settle();
      req_valid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write one register; the enable stays high until close_regs
   task automatic put_reg(input logic [CSR_INDEX_W-1:0] index, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_STACK_LOW:  cfg_stack_low     = value;
         CSR_STACK_HIGH: cfg_stack_high    = value;
         CSR_IMAGE_BASE: cfg_image_base    = value;
         CSR_HND_COUNT:  cfg_count         = value[8:0];
         CSR_SAFE_ON:    cfg_safe_on       = value[0];
         CSR_TABLE_PRES: cfg_table_present = value[0];
         default: ;
      endcase
   endtask

   task automatic close_regs();
      csr_we <= 1'b0;
   endtask

   // pick and write the register setting of one random phase
   task automatic choose_setting(input int unsigned phase);
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] base;
      logic [31:0] count;
      logic [31:0] safe;
      logic [31:0] present;
      lo      = $urandom_range(32'h7FFF_FFFF, 4) & ~ALIGN_MASK;
      hi      = lo + $urandom_range(32'h7FFF_FFFF, 4);
      base    = $urandom();
      count   = $urandom_range(TABLE_DEPTH_DEF, 1);
      safe    = 32'h1;
      present = 32'h1;
      case (phase)
         0: begin
            lo    = 32'h0;
            hi    = 32'h0;
            base  = 32'h0;
            count = TABLE_DEPTH_DEF;
         end
         1: begin
            lo    = 32'h0000_0004;
            hi    = 32'hFFFF_FFFC;
            base  = 32'hFFFF_FFFF;
            count = 32'h0000_01FF;
         end
         2: count = 32'h1;
         3: begin
            lo   = 32'h0;
            safe = 32'h0;
         end
         4: count = 32'h0;
         5: present = 32'h0;
         6: count = $urandom_range(32'h1FF, TABLE_DEPTH_DEF + 1);
         default: begin
            // junk above each narrow register's width must be dropped
            count   = ($urandom() & ~32'h1FF) | $urandom_range(TABLE_DEPTH_DEF + 40, 0);
            safe    = ($urandom() & ~32'h1) | 32'($urandom_range(4) != 0);
            present = ($urandom() & ~32'h1) | 32'($urandom_range(5) != 0);
         end
      endcase
      settle();
      put_reg(CSR_STACK_LOW, lo);
      put_reg(CSR_STACK_HIGH, hi);
      put_reg(CSR_IMAGE_BASE, base);
      put_reg(CSR_HND_COUNT, count);
      put_reg(CSR_SAFE_ON, safe);
      put_reg(CSR_TABLE_PRES, present);
      close_regs();
      settings_seen++;
   endtask

   // rewrite one slot, mostly keeping the table sorted
   task automatic offer_random_load();
      logic [7:0]  slot;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] value;
      slot = 8'($urandom_range(255));
      lo   = (slot == 8'h00) ? 32'h0 : handler_table[slot - 1];
      hi   = (slot == 8'hFF) ? 32'hFFFF_FFFF : handler_table[slot + 1];
      if (lo <= hi && $urandom_range(9) != 0)
         value = $urandom_range(hi, lo);
      else
         value = $urandom();
      send_word(KIND_LOAD, slot, value, $urandom(), $urandom(), $urandom(), 1'b0, STATUS_OK);
   endtask

   // build a mostly well-formed record, then break a quarter of them
   task automatic offer_random_check();
      logic [31:0] rec;
      logic [31:0] nxt;
      logic [31:0] hnd;
      int unsigned live;
      rec = $urandom() & ~ALIGN_MASK;
      if (cfg_stack_low != 0 && cfg_stack_high != 0 && cfg_stack_low <= cfg_stack_high) begin
         case ($urandom_range(9))
            0: rec = cfg_stack_low;
            1: rec = cfg_stack_high;
            2: rec = cfg_stack_low - 4;
            3: rec = cfg_stack_high + 4;
            default: rec = $urandom_range(cfg_stack_high, cfg_stack_low) & ~ALIGN_MASK;
         endcase
      end
      nxt = rec + $urandom_range(32'h1_0000, 1);
      if (nxt <= rec)
         nxt = 32'hFFFF_FFFF;
      live = (cfg_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : cfg_count;
      if (live != 0 && $urandom_range(9) < 7) begin
         hnd = cfg_image_base + handler_table[$urandom_range(live - 1)];
         if ($urandom_range(7) == 0)
            hnd = hnd + 1;
      end else begin
         hnd = $urandom();
      end
      if ($urandom_range(3) == 0) begin
         case ($urandom_range(3))
            0: rec = rec | $urandom_range(3, 1);
            1: nxt = rec - $urandom_range(16, 0);
            2: hnd = 32'h0;
            default: begin
               rec = $urandom();
               nxt = $urandom();
               hnd = $urandom();
            end
         endcase
      end
      send_word(KIND_VERIFY, 8'($urandom()), $urandom(), rec, nxt, hnd, 1'b0, STATUS_OK);
   endtask

   // compare taken statuses in order and pace the receiver
   always @(posedge clock) begin : status_side
      status_type want;
      int         pct;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (status_q.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("unexpected status %0d at %0t", rsp_status, $time);
         end else begin
            want = status_q.pop_front();
            if (rsp_status !== want) begin
               faults++;
               if (faults <= 10)
                  $display("status mismatch at %0t: expected %s, got %0d",
                           $time, want.name(), rsp_status);
            end
         end
      end
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      pct = (pace == PACE_RECEIVER) ? 74 : (pace == PACE_BOTH) ? 32 : 0;
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < pct);
      end
   end

   // end the run if neither channel moves for too long
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      logic [31:0] value;
      bit          in_regs;
      in_regs = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // walk the directed steps
      for (int i = 0; i < DRILL_LEN; i++) begin
         if (drill[i].what == STEP_REG) begin
            if (!in_regs)
               settle();
            in_regs = 1'b1;
            put_reg(drill[i].slot[CSR_INDEX_W-1:0], drill[i].offset);
         end else begin
            if (in_regs)
               close_regs();
            in_regs = 1'b0;
            send_word(drill[i].kind, drill[i].slot, drill[i].offset, drill[i].rec,
                      drill[i].nxt, drill[i].hnd, drill[i].typed, drill[i].status);
         end
      end

      // fill the whole table in ascending order, zero first and all ones last
      pace  = PACE_BOTH;
      value = 32'h0;
      for (int slot = 0; slot < TABLE_DEPTH_DEF; slot++) begin
         if (slot == TABLE_DEPTH_DEF - 1)
            value = 32'hFFFF_FFFF;
         else if (slot != 0)
            value = value + $urandom_range(32'h100_0000, 1);
         send_word(KIND_LOAD, 8'(slot), value, $urandom(), $urandom(), $urandom(),
                   1'b0, STATUS_OK);
      end

      // random phases, each with its own registers and pacing
      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         choose_setting(phase);
         pace = pace_type'(phase % 4);
         if (phase == 0)
            hold_request = 1'b1;
         repeat (WORDS_PER_PHASE) begin
            if ($urandom_range(99) < 15)
               offer_random_load();
            else
               offer_random_check();
         end
      end

      settle();
      faults += status_q.size();
      $display("Covered %0d table loads and %0d record checks over %0d register settings.",
               loads_seen, checks_seen, settings_seen);
      $display("Statuses: %0d ok, %0d bad record, %0d outside stack, %0d not allowed.",
               tally[0], tally[1], tally[2], tally[3]);
      if (faults == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/ehrc_pkg.sv
hdl/ehrc_ctrl.sv
hdl/ehrc_dp.sv
hdl/exception_handler_record_checker.sv
dv/tb_top.sv
